// File: rtl/core/epsc_pkg.sv
package epsc_pkg;

  // Widths fixed by the item fields
  localparam int unsigned IDX_W    = 3;   // channel index in commands (ports: up to 4 motors)
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned MAXSP_W  = 11;
  localparam int unsigned INTVL_W  = 16;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned TGT_W    = 14;
  localparam int unsigned VEL_W    = 7;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned ERR_W    = 15;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned PROD_W   = 57;
  localparam int unsigned ACC_W    = 58;
  localparam int unsigned DUTY_W   = 7;
  localparam int unsigned IN_DW    = 32;
  localparam int unsigned OUT_DW   = 24;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

  // raw/1600 = (raw>>6)/25 = ((raw>>6)*5243)>>17, exact for 10-bit operands
  localparam logic [12:0] POS_RECIP  = 13'd5243;
  localparam int unsigned POS_SHIFT  = 17;
  // x/100 = (x*671089)>>26, exact for 19-bit operands
  localparam logic [19:0] PCT_RECIP  = 20'd671089;
  localparam int unsigned PCT_SHIFT  = 26;

  // Reset values of the registers
  localparam logic [GAIN_W-1:0]  KP_RESET    = 24'd327680;
  localparam logic [GAIN_W-1:0]  KI_RESET    = 24'd655;
  localparam logic [MAXSP_W-1:0] MAXSP_RESET = 11'd800;
  localparam logic [INTVL_W-1:0] INTVL_RESET = 16'd500;

  // Register indexes
  localparam logic [CFG_AW-1:0] CFG_KP    = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_KI    = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_MAXSP = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_INTVL = 2'd3;

  typedef enum logic [1:0] {
    ACT_POS  = 2'd0,
    ACT_TICK = 2'd1,
    ACT_CMD  = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_CAPTURE = 4'd1,
    OP_POS     = 4'd2,
    OP_CMD_MUL = 4'd3,
    OP_CMD_DIV = 4'd4,
    OP_CMD_WR  = 4'd5,
    OP_TICK    = 4'd6,
    OP_LOAD_E  = 4'd7,
    OP_MUL_KP  = 4'd8,
    OP_MUL_KI  = 4'd9,
    OP_ACC     = 4'd10,
    OP_EMIT    = 4'd11
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [IDX_W-1:0] idx;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       out_free;
  } dp_sts_t;

endpackage

// File: rtl/core/encoder_pi_speed_controller.sv
// Position sample: captured, then written. Speed command: captured, scaled, written.
// Tick: each channel in turn runs load error, kp multiply, ki multiply, add, output
//   on the one shared multiplier. One request at a time, taken only in idle; a tick
//   waits at output while the output register is full and not taken. Reset: rst_ni
//   asynchronous active low; registers to defaults, channel state cleared, except
//   targets: channel 0 to 0, the others to 1.
module encoder_pi_speed_controller import epsc_pkg::*; #(
  parameter int unsigned MOTOR_COUNT = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CFG_AW-1:0]   cfg_addr_i,   // 0 kp, 1 ki, 2 max speed, 3 sample interval
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  // Request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [IN_DW-1:0]    s_axis_tdata,  // channel[1:0], raw_count[17:2],
                                             // direction[18], speed_percent[26:19]
  input  logic [1:0]          s_axis_tuser,  // action[1:0]
  // Drive result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OUT_DW-1:0]   m_axis_tdata,  // motor[1:0], duty[8:2], forward[9],
                                             // velocity[16:10]
  output logic                m_axis_tlast   // final channel of a tick
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: one request at a time, steps the channels of a tick
  epsc_ctrl #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: channel state, gain multiplier, output register
  epsc_dp #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .out_tready_i (m_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .out_tdata_o  (m_axis_tdata),
    .out_tlast_o  (m_axis_tlast)
  );

endmodule

// File: rtl/core/epsc_ctrl.sv
module epsc_ctrl import epsc_pkg::*; #(
  parameter int unsigned MOTOR_COUNT = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam int unsigned CW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam logic [CW-1:0] LAST_IDX = CW'(MOTOR_COUNT - 1);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_DECODE  = 10'b00_0000_0010,
    ST_CMD_DIV = 10'b00_0000_0100,
    ST_CMD_WR  = 10'b00_0000_1000,
    ST_TICK    = 10'b00_0001_0000,
    ST_LOAD    = 10'b00_0010_0000,
    ST_MUL_KP  = 10'b00_0100_0000,
    ST_MUL_KI  = 10'b00_1000_0000,
    ST_SUM     = 10'b01_0000_0000,
    ST_OUT     = 10'b10_0000_0000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          is_last;

  assign is_last    = (idx_q == LAST_IDX);
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmd_o.op   = OP_NONE;
    cmd_o.idx  = IDX_W'(idx_q);
    cmd_o.last = is_last;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts_i.action)
          ACT_POS: begin
            cmd_o.op = OP_POS;
            state_d  = ST_IDLE;
          end
          ACT_CMD: begin
            cmd_o.op = OP_CMD_MUL;
            state_d  = ST_CMD_DIV;
          end
          ACT_TICK: begin
            state_d = ST_TICK;
          end
          default: begin
            state_d = ST_IDLE;   // unused action code: dropped
          end
        endcase
      end
      ST_CMD_DIV: begin
        cmd_o.op = OP_CMD_DIV;
        state_d  = ST_CMD_WR;
      end
      ST_CMD_WR: begin
        cmd_o.op = OP_CMD_WR;
        state_d  = ST_IDLE;
      end
      ST_TICK: begin
        cmd_o.op = OP_TICK;
        idx_d    = '0;
        state_d  = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.op = OP_LOAD_E;
        state_d  = ST_MUL_KP;
      end
      ST_MUL_KP: begin
        cmd_o.op = OP_MUL_KP;
        state_d  = ST_MUL_KI;
      end
      ST_MUL_KI: begin
        cmd_o.op = OP_MUL_KI;
        state_d  = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.op = OP_ACC;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_EMIT;
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_EMIT) |-> sts_i.out_free)
    else $error("result loaded while output register still full");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_EMIT && cmd_o.last) |=> (state_q == ST_IDLE))
    else $error("tick did not finish after final channel");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DECODE))
    else $error("accepted request not decoded");

endmodule

// File: rtl/core/epsc_dp.sv
module epsc_dp import epsc_pkg::*; #(
  parameter int unsigned MOTOR_COUNT = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  logic                cfg_we_i,
  input  logic [CFG_AW-1:0]   cfg_addr_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic [IN_DW-1:0]    in_tdata_i,
  input  logic [1:0]          in_tuser_i,
  input  logic                out_tready_i,
  output logic                out_tvalid_o,
  output logic [OUT_DW-1:0]   out_tdata_o,
  output logic                out_tlast_o
);

  localparam int unsigned CW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  // Configuration
  logic [GAIN_W-1:0]  kp_q, ki_q;
  logic [MAXSP_W-1:0] maxsp_q;
  logic [INTVL_W-1:0] intvl_q;

  // Captured request
  logic [1:0]  act_q;
  logic [1:0]  chan_q;
  logic [15:0] raw_q;
  logic        dir_q;
  logic [7:0]  pct_q;

  // Channel state
  logic signed [TGT_W-1:0] tgt_q  [MOTOR_COUNT];
  logic signed [VEL_W-1:0] vel_q  [MOTOR_COUNT];
  logic        [POS_W-1:0] pos_q  [MOTOR_COUNT];
  logic        [POS_W-1:0] prev_q [MOTOR_COUNT];
  logic signed [SUM_W-1:0] sum_q  [MOTOR_COUNT];
  logic        [INTVL_W-1:0] tick_q;

  // Working registers
  logic        [18:0]       cprod_q;
  logic        [12:0]       cquo_q;
  logic signed [ERR_W-1:0]  e_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  // Output register
  logic                    out_valid_q;
  logic [1:0]              out_motor_q;
  logic [DUTY_W-1:0]       out_duty_q;
  logic                    out_fwd_q;
  logic [VEL_W-1:0]        out_vel_q;
  logic                    out_last_q;

  logic [CW-1:0]  idx, ch_idx;
  logic           chan_ok;
  logic [22:0]    pos_prod;
  logic [38:0]    cquo_prod;
  logic [INTVL_W-1:0] tick_inc;
  logic           estimate;

  logic signed [GAIN_W:0]    mul_a;
  logic signed [SUM_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  logic              acc_neg;
  logic [ACC_W-1:0]  acc_mag;
  logic [ACC_W-17:0] u_mag;
  logic [DUTY_W-1:0] duty;
  logic              fwd;
  logic signed [SUM_W:0]   sum_ext;
  logic signed [SUM_W-1:0] sum_sat;
  logic              out_free;

  assign idx      = CW'(cmd_i.idx);
  assign ch_idx   = CW'(chan_q);
  assign chan_ok  = (32'(chan_q) < MOTOR_COUNT);

  assign pos_prod  = 23'(raw_q[15:6]) * 23'(POS_RECIP);
  assign cquo_prod = 39'(cprod_q) * 39'(PCT_RECIP);

  assign tick_inc = tick_q + INTVL_W'(1);
  assign estimate = (tick_inc >= intvl_q);

  // Shared gain multiplier: kp*e, then ki*sum
  always_comb begin
    if (cmd_i.op == OP_MUL_KI) begin
      mul_a = $signed({1'b0, ki_q});
      mul_b = sum_q[idx];
    end else begin
      mul_a = $signed({1'b0, kp_q});
      mul_b = SUM_W'(e_q);
    end
  end
  assign mul_p = mul_a * mul_b;

  // u = acc/65536 toward zero, carried as sign and magnitude
  assign acc_neg = acc_q[ACC_W-1];
  assign acc_mag = acc_neg ? (~acc_q + ACC_W'(1)) : acc_q;
  assign u_mag   = acc_mag[ACC_W-1:16];
  assign duty    = (u_mag > (ACC_W-16)'(DUTY_MAX)) ? DUTY_MAX : u_mag[DUTY_W-1:0];
  assign fwd     = !(acc_neg && (u_mag != '0));

  assign sum_ext = (SUM_W+1)'(sum_q[idx]) + (SUM_W+1)'(e_q);
  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  assign out_free = !out_valid_q || out_tready_i;
  assign sts_o.action   = act_q;
  assign sts_o.out_free = out_free;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= KP_RESET;
      ki_q    <= KI_RESET;
      maxsp_q <= MAXSP_RESET;
      intvl_q <= INTVL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_KP:    kp_q    <= cfg_wdata_i[GAIN_W-1:0];
        CFG_KI:    ki_q    <= cfg_wdata_i[GAIN_W-1:0];
        CFG_MAXSP: maxsp_q <= cfg_wdata_i[MAXSP_W-1:0];
        CFG_INTVL: intvl_q <= cfg_wdata_i[INTVL_W-1:0];
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_CAPTURE: begin
        act_q  <= in_tuser_i;
        chan_q <= in_tdata_i[1:0];
        raw_q  <= in_tdata_i[17:2];
        dir_q  <= in_tdata_i[18];
        pct_q  <= in_tdata_i[26:19];
      end
      OP_CMD_MUL: cprod_q <= 19'(pct_q) * 19'(maxsp_q);
      OP_CMD_DIV: cquo_q  <= cquo_prod[38:PCT_SHIFT];
      OP_LOAD_E:  e_q     <= ERR_W'(tgt_q[idx]) - ERR_W'(vel_q[idx]);
      OP_MUL_KP:  prod_q  <= mul_p;
      OP_MUL_KI: begin
        acc_q  <= ACC_W'(prod_q);
        prod_q <= mul_p;
      end
      OP_ACC:     acc_q   <= acc_q + ACC_W'(prod_q);
      default: ;
    endcase
    if (cmd_i.op == OP_EMIT) begin
      out_motor_q <= 2'(idx);
      out_duty_q  <= duty;
      out_fwd_q   <= fwd;
      out_vel_q   <= vel_q[idx];
      out_last_q  <= cmd_i.last;
    end
  end

  // Channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        tgt_q[i]  <= (i == 0) ? '0 : TGT_W'(1);
        vel_q[i]  <= '0;
        pos_q[i]  <= '0;
        prev_q[i] <= '0;
        sum_q[i]  <= '0;
      end
      tick_q <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_POS: begin
          if (chan_ok) pos_q[ch_idx] <= pos_prod[22:POS_SHIFT];
        end
        OP_CMD_WR: begin
          if (chan_ok) begin
            tgt_q[ch_idx] <= dir_q ? $signed({1'b0, cquo_q}) : -$signed({1'b0, cquo_q});
          end
        end
        OP_TICK: begin
          if (estimate) begin
            tick_q <= '0;
            for (int i = 0; i < MOTOR_COUNT; i++) begin
              vel_q[i]  <= $signed({1'b0, prev_q[i]}) - $signed({1'b0, pos_q[i]});
              prev_q[i] <= pos_q[i];
            end
          end else begin
            tick_q <= tick_inc;
          end
        end
        OP_EMIT: sum_q[idx] <= sum_sat;
        default: ;
      endcase
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tlast_o  = out_last_q;
  assign out_tdata_o  = {7'b0, out_vel_q, out_fwd_q, out_duty_q, out_motor_q};

  a_duty_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_duty_q <= DUTY_MAX))
    else $error("duty above limit");

  a_reverse_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_fwd_q) |-> (out_duty_q != '0))
    else $error("reverse drive with zero duty");

  a_tick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_TICK && estimate) |=> (tick_q == '0))
    else $error("sample counter not cleared on estimate");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import epsc_pkg::*;

  localparam int MOTORS         = 4;
  localparam int COUNTS_PER_POS = 1600;   // encoder counts per position step
  localparam int PCT_FULL       = 100;    // percent scale of a speed command
  localparam int SETTLE_CYCLES  = 32;     // covers a full tick plus slack
  localparam int PHASE_REQUESTS = 100;

  // Action code the block must ignore
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // One drive result as it leaves the block
  typedef struct packed {
    logic               last;
    logic [VEL_W-1:0]   velocity;
    logic               forward;
    logic [DUTY_W-1:0]  duty;
    logic [1:0]         motor;
  } drive_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_AW-1:0]   cfg_addr_i;
  logic [CFG_W-1:0]    cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_DW-1:0]    s_axis_tdata;   // channel[1:0], raw_count[17:2],
                                       // direction[18], speed_percent[26:19]
  logic [1:0]          s_axis_tuser;   // action[1:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_DW-1:0]   m_axis_tdata;   // motor[1:0], duty[8:2], forward[9],
                                       // velocity[16:10]
  logic                m_axis_tlast;

  encoder_pi_speed_controller #(.MOTOR_COUNT(MOTORS)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Speed loop predictor: own copy of registers and channel state
  // ---------------------------------------------------------------------
  logic [GAIN_W-1:0]  kp_r;
  logic [GAIN_W-1:0]  ki_r;
  logic [MAXSP_W-1:0] max_speed_r;
  logic [INTVL_W-1:0] interval_r;
  logic [INTVL_W-1:0] tick_cnt;
  int                 target_vel [MOTORS];
  int                 meas_vel   [MOTORS];
  int                 cur_pos    [MOTORS];
  int                 prev_pos   [MOTORS];
  int                 err_sum    [MOTORS];

  drive_t predicted_drives[$];

  // Idling knobs, in percent
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;

  // Run statistics
  int requests_sent  = 0;
  int ticks_sent     = 0;
  int drives_checked = 0;
  int reg_writes     = 0;
  int mismatches     = 0;

  // Advance the predictor by one accepted request; ticks queue MOTORS drives.
  task automatic predict_request(input logic [1:0] action, input logic [1:0] channel,
                                 input logic [15:0] raw, input logic dir,
                                 input logic [7:0] pct);
    int     mag;
    int     e;
    longint acc;
    longint amag;
    longint umag;
    longint sum;
    drive_t d;
    case (action)
      ACT_POS: cur_pos[channel] = int'(raw) / COUNTS_PER_POS;
      ACT_CMD: begin
        mag = (int'(pct) * int'(max_speed_r)) / PCT_FULL;
        target_vel[channel] = dir ? mag : -mag;
      end
      ACT_TICK: begin
        tick_cnt = tick_cnt + 16'd1;
        // velocity estimate; count >= interval also covers a lowered interval
        if (tick_cnt >= interval_r) begin
          tick_cnt = '0;
          for (int i = 0; i < MOTORS; i++) begin
            meas_vel[i] = prev_pos[i] - cur_pos[i];
            prev_pos[i] = cur_pos[i];
          end
        end
        for (int i = 0; i < MOTORS; i++) begin
          e    = target_vel[i] - meas_vel[i];
          acc  = longint'(kp_r) * longint'(e) + longint'(ki_r) * longint'(err_sum[i]);
          amag = (acc < 0) ? -acc : acc;
          umag = amag >>> 16;   // magnitude truncation = round toward zero
          d.motor    = 2'(i);
          d.duty     = (umag > longint'(DUTY_MAX)) ? DUTY_MAX : umag[DUTY_W-1:0];
          d.forward  = !((acc < 0) && (umag != 0));
          d.velocity = meas_vel[i][VEL_W-1:0];
          d.last     = (i == MOTORS - 1);
          predicted_drives.push_back(d);
          // integral saturates at the 32-bit signed limits
          sum = longint'(err_sum[i]) + longint'(e);
          if (sum > longint'(32'sh7fffffff)) sum = longint'(32'sh7fffffff);
          if (sum < -longint'(33'sh080000000)) sum = -longint'(33'sh080000000);
          err_sum[i] = int'(sum);
        end
        ticks_sent++;
      end
      default: ;  // unused action: no state change, no drive
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Send one request with random idle cycles ahead of it; tvalid stays up on
  // return so back-to-back requests never lower and raise it in one step.
  task automatic send_request(input logic [1:0] action, input logic [1:0] channel,
                              input logic [15:0] raw, input logic dir,
                              input logic [7:0] pct);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, pct, dir, raw, channel};
    s_axis_tuser  <= action;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_request(action, channel, raw, dir, pct);
    if (action != ACT_UNUSED) requests_sent++;
  endtask

  // Hold off requests until every predicted drive has come out.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (predicted_drives.size() != 0) @(posedge clk_i);
  endtask

  // Register write, only with the block idle. A trailing sample or command
  // leaves no drive to wait for, so let a full tick's worth of cycles pass.
  task automatic set_register(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_KP:    kp_r        = value[GAIN_W-1:0];
      CFG_KI:    ki_r        = value[GAIN_W-1:0];
      CFG_MAXSP: max_speed_r = value[MAXSP_W-1:0];
      CFG_INTVL: interval_r  = value[INTVL_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // ---------------------------------------------------------------------
  // Result side: random back-pressure and in-order check
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  drive_t got_drive;
  drive_t want_drive;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_drive.motor    = m_axis_tdata[1:0];
      got_drive.duty     = m_axis_tdata[8:2];
      got_drive.forward  = m_axis_tdata[9];
      got_drive.velocity = m_axis_tdata[16:10];
      got_drive.last     = m_axis_tlast;
      if (predicted_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected drive: motor %0d duty %0d fwd %0b vel %0d last %0b",
                   got_drive.motor, got_drive.duty, got_drive.forward,
                   $signed(got_drive.velocity), got_drive.last);
      end else begin
        want_drive = predicted_drives.pop_front();
        drives_checked++;
        if (got_drive.motor !== want_drive.motor || got_drive.duty !== want_drive.duty ||
            got_drive.forward !== want_drive.forward ||
            got_drive.velocity !== want_drive.velocity ||
            got_drive.last !== want_drive.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"tb: drive mismatch: want m%0d d%0d f%0b v%0d l%0b,",
                      " got m%0d d%0d f%0b v%0d l%0b"},
                     want_drive.motor, want_drive.duty, want_drive.forward,
                     $signed(want_drive.velocity), want_drive.last,
                     got_drive.motor, got_drive.duty, got_drive.forward,
                     $signed(got_drive.velocity), got_drive.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Defaults after reset: channel 0 targets 0, the others 1. Unused action ignored.
  task automatic test_reset_state();
    send_request(ACT_UNUSED, 2'd1, 16'hffff, 1'b1, 8'hff);
    send_request(ACT_TICK, 2'd0, 16'd0, 1'b0, 8'd0);
  endtask

  // Targets at full scale both ways, zero speed, over-100 percent, max speed zero.
  // Full reverse target also gives a negative control value.
  task automatic test_speed_commands();
    set_register(CFG_MAXSP, 24'd2047);
    send_request(ACT_CMD, 2'd0, 16'd0, 1'b1, 8'd255);
    send_request(ACT_CMD, 2'd1, 16'd0, 1'b0, 8'd255);
    send_request(ACT_CMD, 2'd2, 16'd0, 1'b1, 8'd0);
    send_request(ACT_CMD, 2'd3, 16'd0, 1'b0, 8'd1);
    send_request(ACT_TICK, 2'd0, 16'd0, 1'b0, 8'd0);
    set_register(CFG_MAXSP, 24'd0);
    send_request(ACT_CMD, 2'd3, 16'd0, 1'b1, 8'd200);
    send_request(ACT_TICK, 2'd0, 16'd0, 1'b0, 8'd0);
    set_register(CFG_MAXSP, 24'd800);
  endtask

  // Raw count extremes and the 1600 boundary; estimate on every tick so the
  // velocity swings to both ends of its range.
  task automatic test_position_extremes();
    set_register(CFG_INTVL, 24'd1);
    send_request(ACT_POS, 2'd0, 16'hffff, 1'b0, 8'd0);
    send_request(ACT_POS, 2'd1, 16'd0, 1'b1, 8'hff);
    send_request(ACT_POS, 2'd2, 16'd1599, 1'b0, 8'd0);
    send_request(ACT_POS, 2'd3, 16'd1600, 1'b0, 8'd0);
    send_request(ACT_TICK, 2'd0, 16'd0, 1'b0, 8'd0);
    send_request(ACT_POS, 2'd0, 16'd0, 1'b0, 8'd0);
    send_request(ACT_POS, 2'd3, 16'hffff, 1'b0, 8'd0);
    send_request(ACT_TICK, 2'd0, 16'd0, 1'b0, 8'd0);
  endtask

  // Interval of zero fires every tick; an interval lowered below the count
  // fires on the next tick.
  task automatic test_sample_interval();
    send_request(ACT_POS, 2'd1, 16'd32000, 1'b0, 8'd0);
    set_register(CFG_INTVL, 24'd0);
    send_request(ACT_TICK, 2'd0, 16'd0, 1'b0, 8'd0);
    send_request(ACT_TICK, 2'd0, 16'd0, 1'b0, 8'd0);
    set_register(CFG_INTVL, 24'd100);
    send_request(ACT_POS, 2'd1, 16'd0, 1'b0, 8'd0);
    send_request(ACT_TICK, 2'd0, 16'd0, 1'b0, 8'd0);
    send_request(ACT_TICK, 2'd0, 16'd0, 1'b0, 8'd0);
    send_request(ACT_TICK, 2'd0, 16'd0, 1'b0, 8'd0);
    set_register(CFG_INTVL, 24'd2);
    send_request(ACT_TICK, 2'd0, 16'd0, 1'b0, 8'd0);
    set_register(CFG_INTVL, 24'd65535);
  endtask

  // Zero gains, then both gains at full scale.
  task automatic test_gain_extremes();
    set_register(CFG_KP, 24'd0);
    set_register(CFG_KI, 24'd0);
    send_request(ACT_TICK, 2'd0, 16'd0, 1'b0, 8'd0);
    set_register(CFG_KP, 24'hffffff);
    set_register(CFG_KI, 24'hffffff);
    send_request(ACT_TICK, 2'd0, 16'd0, 1'b0, 8'd0);
  endtask

  // One random phase: fresh registers (upper write bits random to check the
  // width masking), then a mix of samples, commands, ticks and unused actions.
  // Note: integral saturation needs ~400k ticks, beyond the run length.
  task automatic run_random_phase(input int src_pct, input int sink_pct);
    int          sent;
    int          pick;
    logic [1:0]  action;
    sent = 0;
    set_register(CFG_KP, ($urandom_range(99) < 20) ? 24'($urandom)
                                                  : 24'($urandom_range(0, 24'h0a0000)));
    set_register(CFG_KI, ($urandom_range(99) < 20) ? 24'($urandom)
                                                  : 24'($urandom_range(0, 2047)));
    set_register(CFG_MAXSP, (24'($urandom) & 24'hfff800) | 24'($urandom_range(0, 2047)));
    set_register(CFG_INTVL, (24'($urandom) & 24'hff0000) | 24'($urandom_range(0, 5)));
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    while (sent < PHASE_REQUESTS) begin
      pick = $urandom_range(99);
      if (pick < 38)      action = ACT_TICK;
      else if (pick < 68) action = ACT_POS;
      else if (pick < 95) action = ACT_CMD;
      else                action = ACT_UNUSED;
      send_request(action, 2'($urandom_range(3)), 16'($urandom_range(65535)),
                   1'($urandom_range(1)), 8'($urandom_range(255)));
      if (action != ACT_UNUSED) sent++;
      // now and then let the output side empty completely
      if ($urandom_range(99) < 3) drain_results();
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0);
    run_random_phase(52, 0);
    run_random_phase(0, 52);
    run_random_phase(29, 29);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= '0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b0;

    kp_r        = KP_RESET;
    ki_r        = KI_RESET;
    max_speed_r = MAXSP_RESET;
    interval_r  = INTVL_RESET;
    tick_cnt    = '0;
    for (int i = 0; i < MOTORS; i++) begin
      target_vel[i] = (i == 0) ? 0 : 1;
      meas_vel[i]   = 0;
      cur_pos[i]    = 0;
      prev_pos[i]   = 0;
      err_sum[i]    = 0;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_speed_commands();
    test_position_extremes();
    test_sample_interval();
    test_gain_extremes();
    test_random_traffic();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("tb: %0d requests (%0d ticks) under four idle/stall mixes, %0d register writes",
             requests_sent, ticks_sent, reg_writes);
    $display("tb: %0d drive results checked, %0d mismatches", drives_checked, mismatches);
    if (mismatches == 0 && predicted_drives.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: fails the run at a time far beyond the slowest legal run
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/epsc_pkg.sv
rtl/core/epsc_ctrl.sv
rtl/core/epsc_dp.sv
rtl/core/encoder_pi_speed_controller.sv
tb/tb.sv
